// ===== hdl/sccc_pkg.sv =====
// Shared types, constants and lookup functions of the sequence composition counter.
package sccc_pkg;

  localparam int SEQ_W    = 32;
  localparam int TOT_W    = 40;
  localparam int CNT_W    = (SEQ_W > TOT_W) ? SEQ_W : TOT_W;
  localparam int NSLOT    = 22;
  localparam int SLOT_W   = 5;
  localparam int NUC_ROWS = 6;
  localparam int PCT_W    = 14;
  localparam int OUT_W    = 40;
  localparam int SEEN_W   = 32;
  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = 2;
  localparam int STEP_W   = 4;

  localparam logic [PCT_W-1:0]  PCT_SCALE = 14'd10000;
  localparam logic [SLOT_W-1:0] SLOT_X    = 5'd19;
  localparam logic [SLOT_W-1:0] SLOT_N    = 5'd4;
  localparam logic [SLOT_W-1:0] SLOT_C    = 5'd1;
  localparam logic [SLOT_W-1:0] SLOT_G    = 5'd2;
  localparam logic [SLOT_W-1:0] ROW_GC    = 5'd6;
  localparam logic [SLOT_W-1:0] ROW_PLAST = 5'd21;

  typedef enum logic [1:0] {
    K_SYM     = 2'd0,
    K_SEQ_END = 2'd1,
    K_ALL_END = 2'd2,
    K_UNUSED  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_MUL  = 2'd1,
    B_DIV  = 2'd2,
    B_EMIT = 2'd3
  } bstate_t;

  localparam logic [7:0] PROT_ALPHA [NSLOT] = '{
    8'h41, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4B, 8'h4C, 8'h4D,
    8'h4E, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h57, 8'h58, 8'h59, 8'h2A
  };
  localparam logic [7:0] NUC_ALPHA [NUC_ROWS] = '{
    8'h41, 8'h43, 8'h47, 8'h54, 8'h4E, 8'h2D
  };

  function automatic logic [SLOT_W-1:0] slot_of(input logic prot, input logic [7:0] ch);
    logic [7:0]        up;
    logic [SLOT_W-1:0] s;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) up = ch - 8'h20;
    if (prot) begin
      s = SLOT_X;
      for (int i = 0; i < NSLOT; i++) begin
        if (PROT_ALPHA[i] == up) s = SLOT_W'(i);
      end
    end else begin
      s = SLOT_N;
      for (int i = 0; i < NUC_ROWS; i++) begin
        if (NUC_ALPHA[i] == up) s = SLOT_W'(i);
      end
    end
    return s;
  endfunction

  function automatic logic [7:0] row_code(input logic prot, input logic [SLOT_W-1:0] row);
    logic [7:0] c;
    c = 8'h00;
    if (prot) begin
      if (row < SLOT_W'(NSLOT)) c = PROT_ALPHA[row];
    end else begin
      if (row < SLOT_W'(NUC_ROWS)) c = NUC_ALPHA[row[2:0]];
    end
    return c;
  endfunction

endpackage

// ===== hdl/sccc_front.sv =====
// Front end: classifies incoming items into alphabet slots and queues them.
module sccc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       in_kind,
  input  logic [7:0]       in_symbol,
  input  logic             prot_mode,
  input  logic             deq,
  output sccc_pkg::q_head_t head
);
  import sccc_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    fill_r, fill_nxt;
  logic               enq, do_deq;
  item_t              new_item;

  assign full   = (fill_r == (QPTR_W+1)'(Q_DEPTH));
  assign do_deq = deq && (fill_r != '0);
  // The unused kind is accepted but never enters the queue.
  assign enq    = push && !full && (kind_t'(in_kind) != K_UNUSED);

  always_comb begin
    new_item.kind = kind_t'(in_kind);
    new_item.slot = slot_of(prot_mode, in_symbol);
    wr_ptr_nxt    = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt    = do_deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt      = fill_r + (QPTR_W+1)'(enq) - (QPTR_W+1)'(do_deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) mem_r[wr_ptr_r] <= new_item;
  end

  assign head.valid = (fill_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

endmodule

// ===== hdl/sccc_back.sv =====
// Back end: counters, table sequencing, percentage divider and result register.
module sccc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sccc_pkg::q_head_t             head,
  output logic                          deq,
  input  logic                          prot_mode,
  input  logic                          rep_en,
  input  logic                          pop,
  output logic                          empty,
  output logic                          out_scope,
  output logic                          out_row_kind,
  output logic [7:0]                    out_symbol_code,
  output logic [sccc_pkg::OUT_W-1:0]    out_count,
  output logic [sccc_pkg::OUT_W-1:0]    out_length,
  output logic [sccc_pkg::PCT_W-1:0]    out_percent_bp,
  output logic [sccc_pkg::SEEN_W-1:0]   out_sequence_number,
  output logic                          out_last
);
  import sccc_pkg::*;

  logic [SEQ_W-1:0]   seq_cnt_r [NSLOT];
  logic [TOT_W-1:0]   cmb_cnt_r [NSLOT];
  logic [SEQ_W-1:0]   seq_len_r;
  logic [TOT_W-1:0]   cmb_len_r;
  logic [SEEN_W-1:0]  seen_r;

  bstate_t            state_r, state_nxt;
  logic [SLOT_W-1:0]  row_r;
  logic               scope_r;
  logic [CNT_W:0]     rem_r;
  logic [PCT_W-1:0]   lo_r;
  logic [STEP_W-1:0]  step_r;
  logic [CNT_W-1:0]   cnt_hold_r, len_hold_r;
  logic               out_v_r;

  logic               do_sym, start_seq, start_all, clr_seq_now;
  logic               load_out, row_last, emit_done;
  logic [CNT_W-1:0]   cnt_arr, g_v, c_v, lim, gc_sum, cnt_row, len_row, clamped;
  logic [CNT_W:0]     raw_sum, trial;
  logic [CNT_W+PCT_W-1:0] prod;
  logic               ge;

  // Row count, product, divider trial and last-row flag for the current table row.
  always_comb begin
    if (scope_r) begin
      cnt_arr = CNT_W'(cmb_cnt_r[row_r]);
      g_v     = CNT_W'(cmb_cnt_r[SLOT_G]);
      c_v     = CNT_W'(cmb_cnt_r[SLOT_C]);
      lim     = CNT_W'({TOT_W{1'b1}});
      len_row = CNT_W'(cmb_len_r);
    end else begin
      cnt_arr = CNT_W'(seq_cnt_r[row_r]);
      g_v     = CNT_W'(seq_cnt_r[SLOT_G]);
      c_v     = CNT_W'(seq_cnt_r[SLOT_C]);
      lim     = CNT_W'({SEQ_W{1'b1}});
      len_row = CNT_W'(seq_len_r);
    end
    raw_sum = {1'b0, g_v} + {1'b0, c_v};
    gc_sum  = (raw_sum > {1'b0, lim}) ? lim : raw_sum[CNT_W-1:0];
    cnt_row = (!prot_mode && row_r == ROW_GC) ? gc_sum : cnt_arr;
    clamped = (cnt_row > len_row) ? len_row : cnt_row;
    prod    = (CNT_W+PCT_W)'(clamped) * (CNT_W+PCT_W)'(PCT_SCALE);
    trial   = {rem_r[CNT_W-1:0], lo_r[PCT_W-1]};
    ge      = (trial >= {1'b0, len_hold_r});
    row_last = prot_mode ? (row_r == ROW_PLAST) : (row_r == ROW_GC);
  end

  always_comb begin
    state_nxt   = state_r;
    deq         = 1'b0;
    do_sym      = 1'b0;
    start_seq   = 1'b0;
    start_all   = 1'b0;
    clr_seq_now = 1'b0;
    load_out    = 1'b0;
    emit_done   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (head.valid) begin
          deq = 1'b1;
          case (head.item.kind)
            K_SYM:     do_sym = 1'b1;
            K_SEQ_END: begin
              start_seq = 1'b1;
              if (rep_en) state_nxt = B_MUL;
              else clr_seq_now = 1'b1;
            end
            K_ALL_END: begin
              start_all = 1'b1;
              state_nxt = B_MUL;
            end
            default: ;
          endcase
        end
      end
      B_MUL:  state_nxt = B_DIV;
      B_DIV:  if (step_r == STEP_W'(PCT_W-1)) state_nxt = B_EMIT;
      B_EMIT: begin
        if (!out_v_r || pop) begin
          load_out = 1'b1;
          if (row_last) begin
            emit_done = 1'b1;
            state_nxt = B_IDLE;
          end else begin
            state_nxt = B_MUL;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // Counters and sequence tally.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        seq_cnt_r[i] <= '0;
        cmb_cnt_r[i] <= '0;
      end
      seq_len_r <= '0;
      cmb_len_r <= '0;
      seen_r    <= '0;
    end else begin
      if (do_sym) begin
        for (int i = 0; i < NSLOT; i++) begin
          if (head.item.slot == SLOT_W'(i)) begin
            if (seq_cnt_r[i] != '1) seq_cnt_r[i] <= seq_cnt_r[i] + 1'b1;
            if (cmb_cnt_r[i] != '1) cmb_cnt_r[i] <= cmb_cnt_r[i] + 1'b1;
          end
        end
        if (seq_len_r != '1) seq_len_r <= seq_len_r + 1'b1;
        if (cmb_len_r != '1) cmb_len_r <= cmb_len_r + 1'b1;
      end
      if (start_seq && seen_r != '1) seen_r <= seen_r + 1'b1;
      if (clr_seq_now || emit_done) begin
        for (int i = 0; i < NSLOT; i++) seq_cnt_r[i] <= '0;
        seq_len_r <= '0;
      end
      if (emit_done && scope_r) begin
        for (int i = 0; i < NSLOT; i++) cmb_cnt_r[i] <= '0;
        cmb_len_r <= '0;
        seen_r    <= '0;
      end
    end
  end

  // Table row sequencing and the bit-serial divider.
  always_ff @(posedge clk) begin
    if (start_seq || start_all) begin
      row_r   <= '0;
      scope_r <= start_all;
    end else if (load_out && !row_last) begin
      row_r <= row_r + 1'b1;
    end
    if (state_r == B_MUL) begin
      rem_r      <= {1'b0, prod[CNT_W+PCT_W-1:PCT_W]};
      lo_r       <= prod[PCT_W-1:0];
      cnt_hold_r <= cnt_row;
      len_hold_r <= len_row;
      step_r     <= '0;
    end else if (state_r == B_DIV) begin
      rem_r  <= ge ? trial - {1'b0, len_hold_r} : trial;
      lo_r   <= {lo_r[PCT_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_scope           <= scope_r;
      out_row_kind        <= !prot_mode && row_r == ROW_GC;
      out_symbol_code     <= row_code(prot_mode, row_r);
      out_count           <= OUT_W'(cnt_hold_r);
      out_length          <= OUT_W'(len_hold_r);
      out_percent_bp      <= (len_hold_r == '0) ? '0 : lo_r;
      out_sequence_number <= seen_r;
      out_last            <= row_last;
    end
  end

  assign empty = !out_v_r;

endmodule

// ===== hdl/sequence_composition_counter_core.sv =====
// A symbol item is written into the queue, then counted when the back end dequeues it;
// one is taken every cycle while no table is being reported. A table row passes through
// one multiply, fourteen divider steps and a load that waits while a result is unread.
// Symbols queue in a four-entry buffer while a table is reported; full rises when it fills.
// Synchronous active-low reset clears all counters, the queue, the registers and the result.
// Top level of the sequence composition counter.
module sequence_composition_counter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    in_kind,
  input  logic [7:0]                    in_symbol,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_scope,
  output logic                          out_row_kind,
  output logic [7:0]                    out_symbol_code,
  output logic [sccc_pkg::OUT_W-1:0]    out_count,
  output logic [sccc_pkg::OUT_W-1:0]    out_length,
  output logic [sccc_pkg::PCT_W-1:0]    out_percent_bp,
  output logic [sccc_pkg::SEEN_W-1:0]   out_sequence_number,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sccc_pkg::*;

  logic    prot_mode_r, rep_en_r;
  logic    deq;
  q_head_t head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prot_mode_r <= 1'b0;
      rep_en_r    <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) rep_en_r <= pwdata[0];
      else prot_mode_r <= pwdata[0];
    end
  end

  assign prdata = {31'd0, paddr[2] ? rep_en_r : prot_mode_r};

  sccc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_kind   (in_kind),
    .in_symbol (in_symbol),
    .prot_mode (prot_mode_r),
    .deq       (deq),
    .head      (head)
  );

  sccc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .deq                 (deq),
    .prot_mode           (prot_mode_r),
    .rep_en              (rep_en_r),
    .pop                 (pop),
    .empty               (empty),
    .out_scope           (out_scope),
    .out_row_kind        (out_row_kind),
    .out_symbol_code     (out_symbol_code),
    .out_count           (out_count),
    .out_length          (out_length),
    .out_percent_bp      (out_percent_bp),
    .out_sequence_number (out_sequence_number),
    .out_last            (out_last)
  );

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present right after reset");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_percent_bp <= PCT_SCALE)
    else $error("percentage above full scale");

  a_gc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_row_kind) |-> out_last)
    else $error("G+C row is not the final row of its table");

  a_pct_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_length == '0) |-> out_percent_bp == '0)
    else $error("non-zero percentage for zero length");

endmodule

// ===== tb/tb.sv =====
// Testbench for the sequence composition counter: directed and random items, checked against a predictor.
`timescale 1ns / 100ps
module tb;
  import sccc_pkg::*;

  localparam logic [2:0] ADDR_PROT = 3'd0;
  localparam logic [2:0] ADDR_REPORT = 3'd4;

  typedef struct packed {
    logic scope;
    logic row_kind;
    logic [7:0] code;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] length;
    logic [PCT_W-1:0] pct;
    logic [SEEN_W-1:0] seq_num;
    logic last;
  } row_t;

  logic clk, rst_n, push, full, empty, pop;
  logic [1:0] in_kind;
  logic [7:0] in_symbol;
  logic out_scope, out_row_kind, out_last;
  logic [7:0] out_symbol_code;
  logic [OUT_W-1:0] out_count, out_length;
  logic [PCT_W-1:0] out_percent_bp;
  logic [SEEN_W-1:0] out_sequence_number;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  sequence_composition_counter_core DUT (.*);

  // Predictor state.
  logic m_prot, m_report;
  logic [63:0] m_seq_cnt [NSLOT];
  logic [63:0] m_all_cnt [NSLOT];
  logic [63:0] m_seq_len, m_all_len;
  logic [31:0] m_seen;
  row_t expected_rows [$];

  int errors = 0;
  bit send_idle = 1;
  bit recv_idle = 1;
  bit hold_req = 0;
  bit hold_taken = 0;
  int hold_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] wmax(int w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 1);
  endfunction

  function automatic logic [PCT_W-1:0] pct_of(logic [63:0] c, logic [63:0] len);
    logic [127:0] p;
    if (len == 0) return '0;
    if (c > len) c = len;
    p = (128'(c) * 10000) / len;
    return p[PCT_W-1:0];
  endfunction

  function automatic logic [4:0] slot_for(logic [7:0] ch);
    logic [7:0] up;
    string pa, na;
    pa = "ACDEFGHIKLMNPQRSTVWXY*";
    na = "ACGTN-";
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    if (m_prot) begin
      for (int i = 0; i < NSLOT; i++) if (pa[i] == up) return 5'(i);
      return SLOT_X;
    end
    for (int i = 0; i < 6; i++) if (na[i] == up) return 5'(i);
    return SLOT_N;
  endfunction

  task automatic add_row(logic sc, logic rk, logic [7:0] code, logic [63:0] c,
                         logic [63:0] len, logic lst);
    row_t r;
    r.scope = sc; r.row_kind = rk; r.code = code;
    r.count = c[OUT_W-1:0]; r.length = len[OUT_W-1:0];
    r.pct = pct_of(c, len); r.seq_num = m_seen; r.last = lst;
    expected_rows = {expected_rows, r};
  endtask

  task automatic predict_table(logic sc, logic [63:0] cnt [NSLOT], logic [63:0] len, int w);
    string pa, na;
    logic [63:0] s;
    pa = "ACDEFGHIKLMNPQRSTVWXY*";
    na = "ACGTN-";
    if (m_prot) begin
      for (int i = 0; i < NSLOT; i++) add_row(sc, 0, pa[i], cnt[i], len, i == NSLOT - 1);
    end else begin
      for (int i = 0; i < 6; i++) add_row(sc, 0, na[i], cnt[i], len, 0);
      s = (cnt[2] > wmax(w) - cnt[1]) ? wmax(w) : cnt[2] + cnt[1];
      add_row(sc, 1, 8'h00, s, len, 1);
    end
  endtask

  task automatic predict_item(logic [1:0] k, logic [7:0] sym);
    logic [4:0] s;
    case (kind_t'(k))
      K_SYM: begin
        s = slot_for(sym);
        if (m_seq_cnt[s] < wmax(SEQ_W)) m_seq_cnt[s]++;
        if (m_all_cnt[s] < wmax(TOT_W)) m_all_cnt[s]++;
        if (m_seq_len < wmax(SEQ_W)) m_seq_len++;
        if (m_all_len < wmax(TOT_W)) m_all_len++;
      end
      K_SEQ_END: begin
        if (m_seen != '1) m_seen++;
        if (m_report) predict_table(0, m_seq_cnt, m_seq_len, SEQ_W);
        foreach (m_seq_cnt[i]) m_seq_cnt[i] = 0;
        m_seq_len = 0;
      end
      K_ALL_END: begin
        predict_table(1, m_all_cnt, m_all_len, TOT_W);
        foreach (m_seq_cnt[i]) begin
          m_seq_cnt[i] = 0;
          m_all_cnt[i] = 0;
        end
        m_seq_len = 0; m_all_len = 0; m_seen = 0;
      end
      default: ;
    endcase
  endtask

  // Push stays high between items sent back to back; it drops in idle gaps.
  task automatic send_item(logic [1:0] k, logic [7:0] sym);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1; in_kind <= k; in_symbol <= sym;
    do @(posedge clk); while (full);
    predict_item(k, sym);
  endtask

  task automatic drain();
    push <= 0;
    while (expected_rows.size() != 0) @(posedge clk);
    // The wait lets symbols still in the queue be counted.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    if (a == ADDR_PROT) m_prot = d[0];
    else m_report = d[0];
  endtask

  task automatic set_mode(logic prot, logic rep);
    drain();
    write_reg(ADDR_PROT, {31'd0, prot});
    write_reg(ADDR_REPORT, {31'd0, rep});
  endtask

  function automatic logic [7:0] rand_symbol(logic prot);
    string na, pa;
    na = "ACGTNacgtn-";
    pa = "ACDEFGHIKLMNPQRSTVWXY*acdefghiklmnpqrstvwxy";
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      default: return prot ? pa[$urandom_range(0, pa.len() - 1)]
                           : na[$urandom_range(0, na.len() - 1)];
    endcase
  endfunction

  task automatic test_directed();
    logic [7:0] syms [10];
    syms = '{8'h00, 8'hFF, "a", "z", "g", "C", "-", "*", "x", 8'h80};
    set_mode(0, 1);
    send_item(K_SEQ_END, 8'hFF);
    send_item(K_ALL_END, 8'h00);
    foreach (syms[i]) send_item(K_SYM, syms[i]);
    send_item(K_UNUSED, "A");
    send_item(K_SEQ_END, 8'hAA);
    send_item(K_SYM, "G");
    set_mode(1, 0);
    send_item(K_SYM, "w");
    send_item(K_SEQ_END, 8'h55);
    send_item(K_SYM, "Q");
    send_item(K_ALL_END, 8'hFF);
  endtask

  task automatic test_random(int n, logic prot, logic rep);
    int sent;
    set_mode(prot, rep);
    sent = 0;
    while (sent < n) begin
      int len;
      len = $urandom_range(0, 30);
      for (int i = 0; i < len; i++) send_item(K_SYM, rand_symbol(prot));
      sent += len;
      case ($urandom_range(0, 9))
        0: send_item(K_UNUSED, 8'($urandom));
        1: send_item(K_ALL_END, 8'($urandom));
        default: send_item(K_SEQ_END, 8'($urandom));
      endcase
      sent++;
    end
    send_item(K_ALL_END, 8'($urandom));
  endtask

  task automatic test_backpressure();
    set_mode(0, 1);
    hold_req = 1;
    send_item(K_SEQ_END, 0);
    for (int i = 0; i < 12; i++) send_item(K_SYM, rand_symbol(0));
    send_item(K_ALL_END, 0);
  endtask

  // Long receiver stall, counted in cycles.
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_cycles <= 300;
      hold_taken  <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // Result checker and receiver idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        row_t got, want;
        got = {out_scope, out_row_kind, out_symbol_code, out_count, out_length,
               out_percent_bp, out_sequence_number, out_last};
        if (expected_rows.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected row %p", got);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("row mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_cycles > 0) begin
        pop <= 0;
      end else begin
        pop <= !(recv_idle && $urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    rst_n = 0; push = 0; in_kind = 0; in_symbol = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    m_prot = 0; m_report = 0; m_seq_len = 0; m_all_len = 0; m_seen = 0;
    foreach (m_seq_cnt[i]) begin
      m_seq_cnt[i] = 0;
      m_all_cnt[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(120, 0, 1);
    test_random(100, 1, 1);
    test_random(80, 0, 0);
    send_idle = 0;
    recv_idle = 0;
    test_random(100, 1, 0);
    set_mode(0, 0);
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
